FILE: rtl/tfpf_pkg.sv
// Shared types, constants and byte-order helpers for the touch firmware packet framer.
// No dependencies; used by tfpf_front, tfpf_queue, tfpf_back and the top level.
package tfpf_pkg;

	localparam int unsigned ENTRY_BYTES = 16;
	localparam int unsigned ENTRY_BITS  = ENTRY_BYTES * 8;
	localparam int unsigned CNT_W       = 5;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam int unsigned IN_DATA_W = 128;
	localparam int unsigned IN_USER_W = 2;

	localparam logic [15:0] REG_HDR  = 16'h1E33;
	localparam logic [31:0] CAL_WORD = 32'h300118E1;

	typedef enum logic [1:0] {
		MODE_REGWR     = 2'd0,
		MODE_CAL_START = 2'd1,
		MODE_CAL_DATA  = 2'd2
	} mode_t;

	// One queued packet fragment: byte i sits in pkt[8*i+7:8*i].
	typedef struct packed {
		logic [ENTRY_BITS-1:0] pkt;
		logic [CNT_W-1:0]      cnt;
		logic                  last;
	} entry_t;

	// Swapped-halfword order: bits 15:8, 7:0, 31:24, 23:16, first byte lowest.
	function automatic logic [31:0] xe(input logic [31:0] w);
		return {w[23:16], w[31:24], w[7:0], w[15:8]};
	endfunction

	// Big-endian halfword, first byte lowest.
	function automatic logic [15:0] be16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	function automatic logic [9:0] byte_sum32(input logic [31:0] w);
		return 10'(w[7:0]) + 10'(w[15:8]) + 10'(w[23:16]) + 10'(w[31:24]);
	endfunction

endpackage

FILE: rtl/tfpf_front.sv
// Front end: accepts input beats, tracks the calibration load state and builds
// packet fragments of up to 16 bytes for the queue. Depends on tfpf_pkg.
module tfpf_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [tfpf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input  logic [tfpf_pkg::IN_USER_W-1:0]    s_axis_tuser,
	input  logic                              full,
	output logic                              push,
	output tfpf_pkg::entry_t                  push_entry
);

	logic [31:0] address;
	logic [31:0] mask;
	logic [31:0] value;
	logic [17:0] length;
	logic [7:0]  data_byte;
	logic        accept;

	logic [17:0] bytes_left_q, bytes_left_n;
	logic [1:0]  padded_left_q, padded_left_n;
	logic [7:0]  held_byte_q, held_byte_n;
	logic        holding_q, holding_n;
	logic [31:0] data_total_q, data_total_n;
	logic        load_open_q, load_open_n;

	logic [15:0] reg_sum;
	logic [18:0] len_p3;
	logic [15:0] words;
	logic [15:0] hdr_sum;
	logic [31:0] tot_n;
	logic [17:0] bl_n;
	logic [15:0] prefix;
	logic [1:0]  pads;
	logic [2:0]  off;

	assign address   = s_axis_tdata[31:0];
	assign mask      = s_axis_tdata[63:32];
	assign value     = s_axis_tdata[95:64];
	assign length    = s_axis_tdata[113:96];
	assign data_byte = s_axis_tdata[121:114];

	assign s_axis_tready = !full;
	assign accept        = s_axis_tvalid && !full;

	assign reg_sum = 16'(tfpf_pkg::byte_sum32(address)) + 16'(tfpf_pkg::byte_sum32(mask))
		+ 16'(tfpf_pkg::byte_sum32(value));
	assign len_p3  = {1'b0, length} + 19'd3;
	assign words   = len_p3[17:2];
	assign hdr_sum = 16'(words[15:8]) + 16'(words[7:0])
		+ 16'(tfpf_pkg::byte_sum32(address));
	assign tot_n   = data_total_q + 32'(data_byte);
	assign bl_n    = bytes_left_q - 18'd1;
	// pair goes out swapped; a lone last byte goes out behind a zero
	assign prefix  = holding_q ? {held_byte_q, data_byte} : {data_byte, 8'h00};
	assign pads    = holding_q ? padded_left_q
		: ((padded_left_q == 2'd0) ? 2'd0 : padded_left_q - 2'd1);
	assign off     = 3'd2 + {1'b0, pads};

	always_comb begin
		push_entry    = '0;
		bytes_left_n  = bytes_left_q;
		padded_left_n = padded_left_q;
		held_byte_n   = held_byte_q;
		holding_n     = holding_q;
		data_total_n  = data_total_q;
		load_open_n   = load_open_q;
		case (s_axis_tuser)
			tfpf_pkg::MODE_REGWR: begin
				if (!load_open_q) begin
					push_entry.pkt = {tfpf_pkg::be16(reg_sum), tfpf_pkg::xe(value),
						tfpf_pkg::xe(mask), tfpf_pkg::xe(address),
						tfpf_pkg::be16(tfpf_pkg::REG_HDR)};
					push_entry.cnt  = tfpf_pkg::CNT_W'(16);
					push_entry.last = 1'b1;
				end
			end
			tfpf_pkg::MODE_CAL_START: begin
				if (!load_open_q) begin
					push_entry.pkt = {32'h0, tfpf_pkg::be16(hdr_sum), tfpf_pkg::xe(address),
						tfpf_pkg::be16(words), tfpf_pkg::xe(tfpf_pkg::CAL_WORD)};
					held_byte_n  = 8'h00;
					holding_n    = 1'b0;
					data_total_n = 32'h0;
					if (length == 18'd0) begin
						// empty load: header plus an all-zero trailer, nothing stays open
						push_entry.cnt  = tfpf_pkg::CNT_W'(16);
						push_entry.last = 1'b1;
					end else begin
						push_entry.cnt = tfpf_pkg::CNT_W'(12);
						bytes_left_n   = length;
						padded_left_n  = 2'd0 - length[1:0];
						load_open_n    = 1'b1;
					end
				end
			end
			tfpf_pkg::MODE_CAL_DATA: begin
				if (load_open_q) begin
					if (bl_n == 18'd0) begin
						push_entry.pkt = {112'h0, prefix}
							| ({96'h0, tfpf_pkg::xe(tot_n)} << {off, 3'b000});
						push_entry.cnt  = tfpf_pkg::CNT_W'(off) + tfpf_pkg::CNT_W'(4);
						push_entry.last = 1'b1;
						bytes_left_n    = 18'd0;
						padded_left_n   = 2'd0;
						held_byte_n     = 8'h00;
						holding_n       = 1'b0;
						data_total_n    = 32'h0;
						load_open_n     = 1'b0;
					end else begin
						bytes_left_n = bl_n;
						data_total_n = tot_n;
						if (holding_q) begin
							push_entry.pkt = {112'h0, prefix};
							push_entry.cnt = tfpf_pkg::CNT_W'(2);
							holding_n      = 1'b0;
						end else begin
							held_byte_n = data_byte;
							holding_n   = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign push = accept && (push_entry.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q  <= '0;
			padded_left_q <= '0;
			held_byte_q   <= '0;
			holding_q     <= 1'b0;
			data_total_q  <= '0;
			load_open_q   <= 1'b0;
		end else if (accept) begin
			bytes_left_q  <= bytes_left_n;
			padded_left_q <= padded_left_n;
			held_byte_q   <= held_byte_n;
			holding_q     <= holding_n;
			data_total_q  <= data_total_n;
			load_open_q   <= load_open_n;
		end
	end

	a_open_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		load_open_q |-> bytes_left_q != 18'd0)
		else $error("load open with no bytes left");

	a_closed_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!load_open_q |-> !holding_q && data_total_q == 32'h0)
		else $error("stale load state while no load open");

endmodule

FILE: rtl/tfpf_queue.sv
// Short fragment queue between front and back end.
// Depends on tfpf_pkg for the entry type.
module tfpf_queue #(
	parameter int unsigned Depth = tfpf_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tfpf_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output tfpf_pkg::entry_t head,
	output logic             head_valid
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	tfpf_pkg::entry_t mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign full       = (count_q == CntW'(Depth));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

FILE: rtl/tfpf_back.sv
// Back end: unloads queued fragments and shifts them out one byte per beat.
// Depends on tfpf_pkg for the entry type.
module tfpf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tfpf_pkg::entry_t head,
	input  logic             head_valid,
	output logic             pop,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata,
	output logic             m_axis_tlast
);

	logic [tfpf_pkg::ENTRY_BITS-1:0] sh_q;
	logic [tfpf_pkg::CNT_W-1:0]      rem_q;
	logic                            last_q;
	logic                            valid_q;
	logic                            take;
	logic                            final_beat;

	assign take       = valid_q && m_axis_tready;
	assign final_beat = (rem_q == tfpf_pkg::CNT_W'(1));
	// next fragment loads behind the last byte of the current one, no bubble
	assign pop        = head_valid && (!valid_q || (take && final_beat));

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = sh_q[7:0];
	assign m_axis_tlast  = last_q && final_beat;

	always_ff @(posedge clk) begin
		if (pop) begin
			sh_q <= head.pkt;
		end else if (take) begin
			sh_q <= sh_q >> 8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			last_q  <= 1'b0;
			valid_q <= 1'b0;
		end else if (pop) begin
			rem_q   <= head.cnt;
			last_q  <= head.last;
			valid_q <= 1'b1;
		end else if (take) begin
			rem_q   <= rem_q - 1'b1;
			valid_q <= !final_beat;
		end
	end

	a_valid_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> rem_q != '0)
		else $error("output valid with no bytes left");

	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> head.cnt != '0)
		else $error("empty fragment in queue");

	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> valid_q)
		else $error("loaded fragment not shown");

endmodule

FILE: rtl/touch_fw_packet_framer_top.sv
// Touch firmware packet framer, top level.
// Frames register writes and calibration loads into an output byte stream.
// Input beat: tuser = mode; tdata = {address, mask, value, length, data_byte}
//   from bit 0 up, zero-filled to 128 bits. Output beat: one byte, tlast on the
//   final byte of each packet.
// A register write (mode 0) yields a 16-byte packet, a load start (mode 1) a
//   12-byte header (16 bytes for an empty load), data bytes (mode 2) leave in
//   swapped pairs; the last data byte adds padding and the 4-byte data sum.
//   Other items while a load is open, and data with none open, give no output.
// When idle, an accepted input beat is written into the fragment queue and then
//   loaded into the back end shifter, which presents the first output byte.
// Throughput: one output byte per cycle while the receiver is ready, set by the
//   back end shifter; a register write occupies 16 output bytes. Input beats are
//   taken each cycle while the fragment queue (QueueDepth entries of up to 16
//   bytes) has room, also while the output is stalled.
// Reset clears the load state and the queue; no load is open afterwards.
// When the receiver stalls the current byte holds and the queue fills, then
//   s_axis_tready drops until it drains.
module touch_fw_packet_framer_top #(
	parameter int unsigned QueueDepth = tfpf_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// address[31:0], mask[63:32], value[95:64], length[113:96], data_byte[121:114]
	input  logic [tfpf_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// mode[1:0]
	input  logic [tfpf_pkg::IN_USER_W-1:0] s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// out_byte[7:0]
	output logic [7:0]                     m_axis_tdata,
	// end_of_packet
	output logic                           m_axis_tlast
);

	logic             push;
	logic             full;
	logic             pop;
	logic             head_valid;
	tfpf_pkg::entry_t push_entry;
	tfpf_pkg::entry_t head;

	tfpf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.full          (full),
		.push          (push),
		.push_entry    (push_entry)
	);

	tfpf_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	tfpf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
